@@ hdl/epm_pkg.sv @@
// Shared types and constants for the Euclidean Prim MST core.
package epm_pkg;

  localparam int MaxPoints = 64;
  localparam int CoordBits = 16;
  localparam int IdxBits   = $clog2(MaxPoints);
  localparam int CntBits   = $clog2(MaxPoints + 1);
  localparam int KeyBits   = 2 * CoordBits + 2;
  localparam int WtBits    = 17;
  localparam int QDepth    = 4;
  localparam int QPtrBits  = $clog2(QDepth);

  typedef struct packed {
    logic signed [15:0] x_coord;
    logic signed [15:0] y_coord;
    logic               last_point;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  point_index;
    logic [5:0]  parent_index;
    logic        is_root;
    logic [16:0] link_weight;
    logic        last_result;
    logic        overflow;
  } out_item_t;

  // Classified command from front to back.
  typedef struct packed {
    logic                        store;
    logic                        build;
    logic [IdxBits-1:0]          addr;
    logic signed [CoordBits-1:0] x;
    logic signed [CoordBits-1:0] y;
    logic [CntBits-1:0]          count;
    logic                        dropped;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_SCAN,
    ST_SCAN_END,
    ST_URD,
    ST_UPD_RD,
    ST_UPD_MUL,
    ST_UPD_SUM,
    ST_OUT_RD,
    ST_OUT_SQRT,
    ST_OUT_EMIT
  } back_state_t;

endpackage

@@ hdl/epm_ram.sv @@
// Generic single-port-write, registered-read RAM.
module epm_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/epm_front.sv @@
// Front end: counts incoming points, flags overflow, issues commands.
module epm_front (
  input  logic               clk,
  input  logic               rst,
  input  epm_pkg::in_item_t  in_item,
  input  logic               in_valid,
  output logic               in_stall,
  output epm_pkg::cmd_t      cmd,
  output logic               cmd_valid,
  input  logic               cmd_full
);

  logic [epm_pkg::CntBits-1:0] count;
  logic                        dropped;
  logic                        fits;
  logic                        take;

  assign in_stall  = cmd_full;
  assign take      = in_valid && !cmd_full;
  assign fits      = count < epm_pkg::CntBits'(epm_pkg::MaxPoints);
  assign cmd_valid = in_valid;

  always_comb begin
    cmd.store   = fits;
    cmd.build   = in_item.last_point;
    cmd.addr    = count[epm_pkg::IdxBits-1:0];
    cmd.x       = in_item.x_coord;
    cmd.y       = in_item.y_coord;
    cmd.count   = fits ? count + 1'b1 : count;
    cmd.dropped = dropped || !fits;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      dropped <= 1'b0;
    end else if (take) begin
      if (in_item.last_point) begin
        count   <= '0;
        dropped <= 1'b0;
      end else begin
        count   <= cmd.count;
        dropped <= cmd.dropped;
      end
    end
  end

endmodule

@@ hdl/epm_queue.sv @@
// Short command FIFO between front and back.
module epm_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  epm_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output epm_pkg::cmd_t head,
  output logic          not_empty
);

  epm_pkg::cmd_t                 slots [epm_pkg::QDepth];
  logic [epm_pkg::QPtrBits-1:0]  wptr;
  logic [epm_pkg::QPtrBits-1:0]  rptr;
  logic [epm_pkg::QPtrBits:0]    used;
  logic                          do_push;
  logic                          do_pop;

  assign full      = used == (epm_pkg::QPtrBits+1)'(epm_pkg::QDepth);
  assign not_empty = used != '0;
  assign head      = slots[rptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) slots[wptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      used <= '0;
    end else begin
      if (do_push) wptr <= wptr + 1'b1;
      if (do_pop)  rptr <= rptr + 1'b1;
      used <= used + (epm_pkg::QPtrBits+1)'(do_push) - (epm_pkg::QPtrBits+1)'(do_pop);
    end
  end

`ifndef ASSERT_OFF
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    full |=> used != '0) else $error("queue lost entries while full");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    used <= (epm_pkg::QPtrBits+1)'(epm_pkg::QDepth)) else $error("queue count too large");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !do_push) |=> used == $past(used) - 1'b1) else $error("pop count slip");
`endif

endmodule

@@ hdl/epm_sqrt.sv @@
// Iterative floor square root, one result bit per cycle.
module epm_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [epm_pkg::KeyBits-1:0] radicand,
  output logic                        done,
  output logic [epm_pkg::WtBits-1:0]  root
);

  localparam int Steps = epm_pkg::KeyBits / 2;
  localparam int StBits = $clog2(Steps + 1);

  logic [epm_pkg::KeyBits-1:0] rem;
  logic [epm_pkg::KeyBits-1:0] num;
  logic [Steps-1:0]            res;
  logic [StBits-1:0]           left;
  logic [epm_pkg::KeyBits+1:0] trial;
  logic [epm_pkg::KeyBits+1:0] rem_sh;

  assign rem_sh = {rem, num[epm_pkg::KeyBits-1 -: 2]};
  assign trial  = {res, 2'b01};
  assign done   = left == '0;
  assign root   = epm_pkg::WtBits'(res);

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= '0;
    end else if (start) begin
      left <= StBits'(Steps);
      rem  <= '0;
      num  <= radicand;
      res  <= '0;
    end else if (!done) begin
      left <= left - 1'b1;
      num  <= num << 2;
      if (rem_sh >= trial) begin
        rem <= epm_pkg::KeyBits'(rem_sh - trial);
        res <= {res[Steps-2:0], 1'b1};
      end else begin
        rem <= epm_pkg::KeyBits'(rem_sh);
        res <= {res[Steps-2:0], 1'b0};
      end
    end
  end

endmodule

@@ hdl/epm_back.sv @@
// Back end: point stores, Prim build sequencer, result emission.
module epm_back (
  input  logic               clk,
  input  logic               rst,
  input  epm_pkg::cmd_t      cmd,
  input  logic               cmd_valid,
  output logic               cmd_pop,
  output epm_pkg::out_item_t out_item,
  output logic               out_valid,
  input  logic               out_stall
);

  localparam int IB = epm_pkg::IdxBits;
  localparam int CB = epm_pkg::CntBits;
  localparam int KB = epm_pkg::KeyBits;
  localparam int CW = epm_pkg::CoordBits;

  epm_pkg::back_state_t state, state_next;

  // Stores
  logic          x_we, y_we, k_we, p_we;
  logic [IB-1:0] x_wa, k_wa, p_wa, x_ra, u_ra, k_ra, p_ra;
  logic [CW-1:0] x_wd, y_wd, x_rd, y_rd, ux_rd, uy_rd;
  logic [KB-1:0] k_wd, k_rd;
  logic [IB-1:0] p_wd, p_rd;
  logic [epm_pkg::MaxPoints-1:0] joined;

  epm_ram #(.Width(CW), .Depth(epm_pkg::MaxPoints)) u_xram (
    .clk, .we(x_we), .waddr(x_wa), .wdata(x_wd), .raddr(x_ra), .rdata(x_rd));
  epm_ram #(.Width(CW), .Depth(epm_pkg::MaxPoints)) u_yram (
    .clk, .we(y_we), .waddr(x_wa), .wdata(y_wd), .raddr(x_ra), .rdata(y_rd));
  epm_ram #(.Width(CW), .Depth(epm_pkg::MaxPoints)) u_uxram (
    .clk, .we(x_we), .waddr(x_wa), .wdata(x_wd), .raddr(u_ra), .rdata(ux_rd));
  epm_ram #(.Width(CW), .Depth(epm_pkg::MaxPoints)) u_uyram (
    .clk, .we(y_we), .waddr(x_wa), .wdata(y_wd), .raddr(u_ra), .rdata(uy_rd));
  epm_ram #(.Width(KB), .Depth(epm_pkg::MaxPoints)) u_kram (
    .clk, .we(k_we), .waddr(k_wa), .wdata(k_wd), .raddr(k_ra), .rdata(k_rd));
  epm_ram #(.Width(IB), .Depth(epm_pkg::MaxPoints)) u_pram (
    .clk, .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));

  // Run registers
  logic [CB-1:0] n;
  logic          dropped;
  logic [CB-1:0] idx;
  logic [CB-1:0] rounds;
  logic [IB-1:0] u_sel;
  logic          u_found;
  logic [KB-1:0] u_key;
  logic [CW:0]   dx, dy;
  logic [KB-1:0] dx2, dy2;
  logic [KB-1:0] dsum;
  logic [IB-1:0] rd_idx;
  logic          rd_live;
  logic [IB-1:0] out_idx;
  logic [IB-1:0] out_par;

  logic        sq_go;
  logic        sq_done;
  logic [16:0] sq_root;

  epm_sqrt u_sqrt (.clk, .rst, .start(sq_go), .radicand(k_rd), .done(sq_done),
    .root(sq_root));

  logic idx_end;
  assign idx_end = idx == n;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      epm_pkg::ST_IDLE:     if (cmd_valid && cmd.build) state_next = epm_pkg::ST_INIT;
      epm_pkg::ST_INIT:     if (idx_end) state_next = epm_pkg::ST_SCAN;
      epm_pkg::ST_SCAN:     if (idx_end) state_next = epm_pkg::ST_SCAN_END;
      epm_pkg::ST_SCAN_END: state_next = (rounds == n || !u_found) ? epm_pkg::ST_OUT_RD
                                                                   : epm_pkg::ST_URD;
      epm_pkg::ST_URD:      state_next = epm_pkg::ST_UPD_RD;
      epm_pkg::ST_UPD_RD:   state_next = epm_pkg::ST_UPD_MUL;
      epm_pkg::ST_UPD_MUL:  state_next = epm_pkg::ST_UPD_SUM;
      epm_pkg::ST_UPD_SUM:  state_next = idx_end ? epm_pkg::ST_SCAN : epm_pkg::ST_UPD_RD;
      epm_pkg::ST_OUT_RD:   state_next = epm_pkg::ST_OUT_SQRT;
      // first cycle here launches the root, so done is stale until it drops
      epm_pkg::ST_OUT_SQRT: if (sq_done && !sq_go) state_next = epm_pkg::ST_OUT_EMIT;
      epm_pkg::ST_OUT_EMIT: if (!out_stall)
                              state_next = (CB'(out_idx) + 1'b1 == n) ? epm_pkg::ST_IDLE
                                                                      : epm_pkg::ST_OUT_RD;
      default:              state_next = epm_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    cmd_pop  = 1'b0;
    x_we     = 1'b0;
    y_we     = 1'b0;
    x_wa     = cmd.addr;
    x_wd     = cmd.x;
    y_wd     = cmd.y;
    k_we     = 1'b0;
    k_wa     = idx[IB-1:0];
    k_wd     = '1;
    p_we     = 1'b0;
    p_wa     = rd_idx;
    p_wd     = u_sel;
    x_ra     = idx[IB-1:0];
    u_ra     = u_sel;
    k_ra     = idx[IB-1:0];
    p_ra     = out_idx;
    out_valid = 1'b0;
    unique case (state)
      epm_pkg::ST_IDLE: begin
        cmd_pop = cmd_valid;
        x_we    = cmd_valid && cmd.store;
        y_we    = cmd_valid && cmd.store;
      end
      epm_pkg::ST_INIT: begin
        k_we = !idx_end;
        k_wd = (idx == '0) ? '0 : '1;
        p_we = !idx_end && idx == '0;
        p_wa = '0;
        p_wd = '0;
      end
      // old key of the point under update lands in the sum cycle
      epm_pkg::ST_UPD_MUL: k_ra = rd_idx;
      epm_pkg::ST_UPD_SUM: begin
        k_we = rd_live && (dsum < k_rd);
        k_wa = rd_idx;
        k_wd = dsum;
        p_we = k_we;
      end
      epm_pkg::ST_OUT_RD:   k_ra = out_idx;
      epm_pkg::ST_OUT_SQRT: k_ra = out_idx;
      epm_pkg::ST_OUT_EMIT: out_valid = 1'b1;
      default: ;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= epm_pkg::ST_IDLE;
      joined <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        epm_pkg::ST_IDLE: if (cmd_valid && cmd.build) begin
          n       <= cmd.count;
          dropped <= cmd.dropped;
          idx     <= '0;
          rounds  <= '0;
          joined  <= '0;
        end
        epm_pkg::ST_INIT: begin
          idx     <= idx_end ? '0 : idx + 1'b1;
          rd_live <= 1'b0;
          u_found <= 1'b0;
        end
        epm_pkg::ST_SCAN: begin
          // key read of previous index arrives now
          if (rd_live && !joined[rd_idx] && (!u_found || k_rd < u_key)) begin
            u_found <= 1'b1;
            u_sel   <= rd_idx;
            u_key   <= k_rd;
          end
          rd_live <= !idx_end;
          rd_idx  <= idx[IB-1:0];
          if (!idx_end) idx <= idx + 1'b1;
        end
        epm_pkg::ST_SCAN_END: begin
          if (rd_live && !joined[rd_idx] && (!u_found || k_rd < u_key)) begin
            u_found <= 1'b1;
            u_sel   <= rd_idx;
          end
          rd_live <= 1'b0;
          idx     <= '0;
        end
        epm_pkg::ST_URD: begin
          joined[u_sel] <= 1'b1;
          rounds        <= rounds + 1'b1;
        end
        epm_pkg::ST_UPD_RD: begin
          rd_idx  <= idx[IB-1:0];
          rd_live <= !joined[idx[IB-1:0]];
          idx     <= idx + 1'b1;
        end
        epm_pkg::ST_UPD_MUL: begin
          dx <= ($signed(x_rd) >= $signed(ux_rd))
                ? (CW+1)'($signed(x_rd) - $signed(ux_rd))
                : (CW+1)'($signed(ux_rd) - $signed(x_rd));
          dy <= ($signed(y_rd) >= $signed(uy_rd))
                ? (CW+1)'($signed(y_rd) - $signed(uy_rd))
                : (CW+1)'($signed(uy_rd) - $signed(y_rd));
        end
        epm_pkg::ST_UPD_SUM: begin
          if (idx_end) begin
            idx     <= '0;
            u_found <= 1'b0;
            rd_live <= 1'b0;
          end
        end
        epm_pkg::ST_OUT_RD: ;
        epm_pkg::ST_OUT_SQRT: ;
        epm_pkg::ST_OUT_EMIT: if (!out_stall) out_idx <= out_idx + 1'b1;
        default: ;
      endcase
      if (state == epm_pkg::ST_SCAN_END) out_idx <= '0;
      // parent read issued in the read cycle is valid on the launch cycle
      if (sq_go) out_par <= p_rd;
    end
  end

  // Squares of the registered differences, summed for the key compare
  assign dx2  = KB'(dx * dx);
  assign dy2  = KB'(dy * dy);
  assign dsum = dx2 + dy2;

  // sqrt launched the cycle the key read lands
  always_ff @(posedge clk) begin
    if (rst) sq_go <= 1'b0;
    else     sq_go <= state == epm_pkg::ST_OUT_RD;
  end

  always_comb begin
    out_item.point_index  = out_idx;
    out_item.is_root      = out_idx == '0;
    out_item.parent_index = out_item.is_root ? '0 : out_par;
    out_item.link_weight  = out_item.is_root ? '0 : sq_root;
    out_item.last_result  = CB'(out_idx) + 1'b1 == n;
    out_item.overflow     = dropped;
  end

`ifndef ASSERT_OFF
  a_emit_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> CB'(out_idx) < n) else $error("result index beyond point count");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(out_idx))
    else $error("result changed while stalled");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> state == epm_pkg::ST_IDLE) else $error("command taken mid-build");
`endif

endmodule

@@ hdl/euclidean_prim_mst_core.sv @@
// Top level of the Euclidean Prim minimum spanning tree core.
// Points arrive one transfer per cycle and are stored until the one marked last;
// then a dense Prim build runs over the N stored points (N up to 64) rooted at
// point 0, and N results stream out in index order. Load costs one cycle per
// point while the command queue has room; the build repeats, per round, a key
// scan (one key read per cycle plus the pick) and a distance update that takes
// every point through read, multiply and sum states, and each result then
// passes through the bit-serial square root. Points beyond 64 are dropped and
// reported by overflow on every result of that run.
module euclidean_prim_mst_core (
  input  logic               clk,
  input  logic               rst,
  input  epm_pkg::in_item_t  in_data,
  input  logic               in_valid,
  output logic               in_stall,
  output epm_pkg::out_item_t out_data,
  output logic               out_valid,
  input  logic               out_stall
);

  epm_pkg::cmd_t fcmd, qhead;
  logic          fvalid, qfull, qpop, qne;

  epm_front u_front (.clk, .rst, .in_item(in_data), .in_valid, .in_stall,
    .cmd(fcmd), .cmd_valid(fvalid), .cmd_full(qfull));

  epm_queue u_queue (.clk, .rst, .push(fvalid), .push_data(fcmd), .full(qfull),
    .pop(qpop), .head(qhead), .not_empty(qne));

  epm_back u_back (.clk, .rst, .cmd(qhead), .cmd_valid(qne), .cmd_pop(qpop),
    .out_item(out_data), .out_valid, .out_stall);

endmodule

@@ test/euclidean_prim_mst_core_tb.sv @@
// Self-checking testbench for the Euclidean Prim minimum spanning tree core.
module euclidean_prim_mst_core_tb;

  localparam int NumRandomPoints = 470;

  logic               clk;
  logic               rst;
  epm_pkg::in_item_t  in_data;
  logic               in_valid;
  logic               in_stall;
  epm_pkg::out_item_t out_data;
  logic               out_valid;
  logic               out_stall;

  euclidean_prim_mst_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall)
  );

  // Predictor state: a private copy of the point store and per-run bookkeeping.
  logic signed [15:0] pt_x [epm_pkg::MaxPoints];
  logic signed [15:0] pt_y [epm_pkg::MaxPoints];
  int                 pt_count;
  bit                 pt_dropped;

  epm_pkg::out_item_t tree_links_q [$];
  int                 error_count;
  bit                 quiet_phase;   // no idling near the end of the run

  // Typed-in final results: lone root point, and two opposite corners.
  localparam epm_pkg::out_item_t WantRoot   = '{6'd0, 6'd0, 1'b1, 17'd0, 1'b1, 1'b0};
  localparam epm_pkg::out_item_t WantCorner = '{6'd1, 6'd0, 1'b0, 17'd92680, 1'b1, 1'b0};

  // Directed rows: a point, its last mark, and an optional typed-in final
  // result of the run that the row closes.
  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               last;
    bit                 typed;
    epm_pkg::out_item_t want;
  } point_row_t;

  point_row_t directed_rows [$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Ends a hung run; sized for many full 64-point builds with stalls.
  initial begin
    #400_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [33:0] sq_distance(int a, int b);
    logic [16:0] dx;
    logic [16:0] dy;
    dx = (pt_x[a] >= pt_x[b]) ? 17'(pt_x[a] - pt_x[b]) : 17'(pt_x[b] - pt_x[a]);
    dy = (pt_y[a] >= pt_y[b]) ? 17'(pt_y[a] - pt_y[b]) : 17'(pt_y[b] - pt_y[a]);
    return 34'(dx * dx) + 34'(dy * dy);
  endfunction

  function automatic logic [16:0] isqrt(logic [33:0] n);
    logic [33:0] root;
    root = 0;
    for (int b = 16; b >= 0; b--) begin
      logic [33:0] trial;
      trial = root | (34'd1 << b);
      if (trial * trial <= n) root = trial;
    end
    return root[16:0];
  endfunction

  // Load one point into the predictor; on the last point build the tree
  // and queue one expected result per stored point.
  task automatic predict_point(logic signed [15:0] x, logic signed [15:0] y,
                               logic last);
    logic [34:0]        key [epm_pkg::MaxPoints];
    bit                 in_tree [epm_pkg::MaxPoints];
    int                 parent [epm_pkg::MaxPoints];
    int                 u;
    logic [33:0]        d;
    epm_pkg::out_item_t r;
    if (pt_count < epm_pkg::MaxPoints) begin
      pt_x[pt_count] = x;
      pt_y[pt_count] = y;
      pt_count++;
    end else begin
      pt_dropped = 1'b1;
    end
    if (!last) return;
    for (int i = 0; i < epm_pkg::MaxPoints; i++) begin
      key[i] = '1;
      in_tree[i] = 0;
      parent[i] = 0;
    end
    key[0] = 0;
    for (int round = 0; round < pt_count; round++) begin
      u = -1;
      for (int i = 0; i < pt_count; i++)
        if (!in_tree[i] && (u < 0 || key[i] < key[u])) u = i;
      in_tree[u] = 1;
      for (int v = 0; v < pt_count; v++) begin
        if (!in_tree[v]) begin
          d = sq_distance(u, v);
          if ({1'b0, d} < key[v]) begin
            key[v] = {1'b0, d};
            parent[v] = u;
          end
        end
      end
    end
    for (int i = 0; i < pt_count; i++) begin
      r.point_index  = 6'(i);
      r.parent_index = (i == 0) ? 6'd0 : 6'(parent[i]);
      r.is_root      = (i == 0);
      r.link_weight  = (i == 0) ? 17'd0 : isqrt(key[i][33:0]);
      r.last_result  = (i + 1 == pt_count);
      r.overflow     = pt_dropped;
      tree_links_q.push_back(r);
    end
    pt_count = 0;
    pt_dropped = 0;
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  // Output side: random stall bursts, compare every accepted transfer.
  initial begin
    out_stall = 1'b1;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 9)) @(negedge clk);
      end
      out_stall = 1'b0;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    epm_pkg::out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (tree_links_q.size() == 0) begin
        report_mismatch("unexpected result, point_index", out_data.point_index, -1);
      end else begin
        want = tree_links_q.pop_front();
        if (out_data.point_index !== want.point_index)
          report_mismatch("point_index", out_data.point_index, want.point_index);
        if (out_data.parent_index !== want.parent_index)
          report_mismatch("parent_index", out_data.parent_index, want.parent_index);
        if (out_data.is_root !== want.is_root)
          report_mismatch("is_root", out_data.is_root, want.is_root);
        if (out_data.link_weight !== want.link_weight)
          report_mismatch("link_weight", out_data.link_weight, want.link_weight);
        if (out_data.last_result !== want.last_result)
          report_mismatch("last_result", out_data.last_result, want.last_result);
        if (out_data.overflow !== want.overflow)
          report_mismatch("overflow", out_data.overflow, want.overflow);
      end
    end
  end

  // One input transfer; valid stays high across back-to-back points.
  task automatic send_point(logic signed [15:0] x, logic signed [15:0] y,
                            logic last);
    if (!quiet_phase && $urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_data.x_coord    = x;
    in_data.y_coord    = y;
    in_data.last_point = last;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_point(x, y, last);
    @(negedge clk);
  endtask

  function automatic logic signed [15:0] rand_coord(int spread);
    case ($urandom_range(0, 5))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      default: return 16'($urandom_range(0, spread) - spread / 2);
    endcase
  endfunction

  // Random run of n points; optionally pushes past capacity.
  task automatic send_run(int n, int spread);
    for (int i = 0; i < n; i++)
      send_point(rand_coord(spread), rand_coord(spread), i == n - 1);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (tree_links_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    int sent;
    int n;
    error_count = 0;
    quiet_phase = 0;
    pt_count = 0;
    pt_dropped = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // Directed: single point (root only), extremes, equal-key ties, duplicates.
    directed_rows = '{
      '{16'sd5, -16'sd7, 1'b1, 1'b1, WantRoot},
      '{16'sh8000, 16'sh8000, 1'b0, 1'b0, '0},
      '{16'sh7FFF, 16'sh7FFF, 1'b1, 1'b1, WantCorner},
      '{16'sd0, 16'sd0, 1'b0, 1'b0, '0}, '{16'sd3, 16'sd4, 1'b0, 1'b0, '0},
      '{-16'sd3, -16'sd4, 1'b0, 1'b0, '0}, '{16'sd4, -16'sd3, 1'b0, 1'b0, '0},
      '{16'sd3, 16'sd4, 1'b1, 1'b0, '0},
      '{16'sh7FFF, 16'sh8000, 1'b0, 1'b0, '0}, '{16'sh8000, 16'sh7FFF, 1'b0, 1'b0, '0},
      '{16'sd0, 16'sd0, 1'b1, 1'b0, '0},
      '{-16'sd1, 16'sd1, 1'b0, 1'b0, '0}, '{16'sd1, -16'sd1, 1'b1, 1'b0, '0}
    };
    foreach (directed_rows[i]) begin
      send_point(directed_rows[i].x, directed_rows[i].y, directed_rows[i].last);
      // typed-in value stands in for the final predicted result of the run
      if (directed_rows[i].typed)
        tree_links_q[tree_links_q.size() - 1] = directed_rows[i].want;
    end
    wait_drained();

    // Capacity: 64 stored, 3 dropped, last one dropped still triggers build.
    send_run(67, 2000);
    sent = directed_rows.size() + 67;
    // Sender holds off until all results are out.
    wait_drained();

    while (sent < NumRandomPoints) begin
      case ($urandom_range(0, 9))
        0:       n = $urandom_range(40, 64);
        1:       n = 65 + $urandom_range(0, 2);
        default: n = $urandom_range(1, 12);
      endcase
      if (n > NumRandomPoints - sent) n = NumRandomPoints - sent;
      if (sent > NumRandomPoints - 60) quiet_phase = 1;
      send_run(n, ($urandom_range(0, 1) != 0) ? 65535 : 40);
      sent += n;
    end
    wait_drained();
    repeat (200) @(negedge clk);

    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ files.f @@
hdl/epm_pkg.sv
hdl/epm_ram.sv
hdl/epm_front.sv
hdl/epm_queue.sv
hdl/epm_sqrt.sv
hdl/epm_back.sv
hdl/euclidean_prim_mst_core.sv
test/euclidean_prim_mst_core_tb.sv
